// ----- rtl/core/fall_alert_controller_macros.svh -----
// Assertion helpers shared by the fall alert controller RTL.
`ifndef FALL_ALERT_CONTROLLER_MACROS_SVH
`define FALL_ALERT_CONTROLLER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define FAC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fall alert controller: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define FAC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fall alert controller: next-cycle check failed");

`endif

// ----- rtl/core/fac_pkg.sv -----
`timescale 1ns / 1ps

package fac_pkg;

   // Alert sequence states, encoded as reported on alert_state
   typedef enum logic [2:0] {
      MODE_READY     = 3'd0,
      MODE_COUNTDOWN = 3'd1,
      MODE_ACTIVE    = 3'd2,
      MODE_TRANSMIT  = 3'd3,
      MODE_RESOLVED  = 3'd4
   } fac_mode_type;

   // Alert kind codes
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_MANUAL = 2'd1;
   localparam logic [1:0] KIND_FALL   = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNTDOWN  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOW_BLINK = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAST_BLINK = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLEANUP    = 3'd4;

   // Saturation limits of the counters
   localparam logic [3:0]  LOW_RUN_MAX = 4'hF;
   localparam logic [15:0] PHASE_MAX   = 16'hFFFF;
   localparam logic [9:0]  BLINK_MAX   = 10'h3FF;

   typedef struct packed {
      logic button_level;
      logic fall_flag;
   } fac_req_type;

   typedef struct packed {
      logic [2:0] alert_state;
      logic [1:0] alert_kind;
      logic       green_led;
      logic       red_led;
      logic       clear_fall;
      logic       press_confirmed;
   } fac_rsp_type;

   typedef struct packed {
      logic [3:0]  debounce_ticks;
      logic [15:0] countdown_ticks;
      logic [9:0]  slow_blink_ticks;
      logic [9:0]  fast_blink_ticks;
      logic [9:0]  cleanup_ticks;
   } fac_cfg_type;

   typedef struct packed {
      fac_mode_type mode;
      logic [1:0]   kind;
      logic         press_pending;
      logic [3:0]   low_run;
      logic         seen_released;
      logic [15:0]  phase_ticks;
      logic [9:0]   blink_ticks;
      logic         red_level;
      logic         green_level;
      logic         blink_phase;
   } fac_state_type;

   localparam fac_cfg_type CFG_RESET = '{
      debounce_ticks:   4'd3,
      countdown_ticks:  16'd300,
      slow_blink_ticks: 10'd10,
      fast_blink_ticks: 10'd2,
      cleanup_ticks:    10'd40
   };

   localparam fac_state_type STATE_RESET = '{
      mode:          MODE_READY,
      kind:          KIND_NONE,
      press_pending: 1'b0,
      low_run:       4'd0,
      seen_released: 1'b1,
      phase_ticks:   16'd0,
      blink_ticks:   10'd0,
      red_level:     1'b0,
      green_level:   1'b0,
      blink_phase:   1'b0
   };

endpackage

// ----- rtl/core/fall_alert_controller.sv -----
`timescale 1ns / 1ps
`include "fall_alert_controller_macros.svh"

// Fall alert controller, one transaction per 50 ms tick.
// Request channel (req_valid, req_stall, req_data) carries the raw button
// level and the fall flag of one tick. Response channel (rsp_valid,
// rsp_stall, rsp_data) returns exactly one result per tick: alert state,
// alert kind, green and red LED levels, the clear-fall pulse and the
// press-confirmed flag, in request order.
// Path: an accepted tick is registered in the input register, then evaluated
// against the state registers while the result register loads.
// Throughput: one tick per cycle. The input register takes a new tick while
// a result waits, and stalls only when both registers are full and the
// receiver stalls; req_stall then follows rsp_stall in the same cycle.
// Configuration: csr_valid/csr_ready with csr_index and csr_wdata; always
// ready, write only while no tick is in flight. Indexes beyond the list
// are ignored.
// Reset (synchronous, active high): empties both registers, restores the
// register defaults and returns the sequence to READY with LEDs off.
module fall_alert_controller import fac_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fac_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output fac_rsp_type                rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   fac_cfg_type   cfg_ff, cfg_in;
   fac_state_type state_ff, state_in;
   fac_req_type   req_ff;
   fac_rsp_type   rsp_ff, rsp_in;
   logic          in_valid_ff, in_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          advance;
   logic          req_accept;

   // Move the held tick into the result register when it has room
   assign advance      = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !advance;
   assign req_accept   = req_valid && !req_stall;
   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   cfg_in.debounce_ticks   = csr_wdata[3:0];
            CSR_COUNTDOWN:  cfg_in.countdown_ticks  = csr_wdata[15:0];
            CSR_SLOW_BLINK: cfg_in.slow_blink_ticks = csr_wdata[9:0];
            CSR_FAST_BLINK: cfg_in.fast_blink_ticks = csr_wdata[9:0];
            CSR_CLEANUP:    cfg_in.cleanup_ticks    = csr_wdata[9:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   fac_step u_step (
      .state_ff (state_ff),
      .cfg      (cfg_ff),
      .req      (req_ff),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         state_ff     <= STATE_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // After the first resolved tick both LEDs stay dark
   `FAC_ASSERT_NOW(a_resolved_leds_off, state_ff.mode == MODE_RESOLVED && state_ff.phase_ticks != 16'd0, !state_ff.green_level && !state_ff.red_level)
   `FAC_ASSERT_NOW(a_clear_kind_none, rsp_valid_ff && rsp_ff.clear_fall, rsp_ff.alert_kind == KIND_NONE)
   `FAC_ASSERT_NEXT(a_active_one_tick, advance && state_ff.mode == MODE_ACTIVE, state_ff.mode == MODE_TRANSMIT)
   `FAC_ASSERT_NEXT(a_held_tick_kept, in_valid_ff && !advance, in_valid_ff)

endmodule

// ----- rtl/core/fac_step.sv -----
`timescale 1ns / 1ps

// Next-state logic for one tick: debounce, alert sequence, blinker and result.
module fac_step import fac_pkg::*; (
   input  fac_state_type state_ff,
   input  fac_cfg_type   cfg,
   input  fac_req_type   req,
   output fac_state_type state_in,
   output fac_rsp_type   rsp
);

   logic        pending;
   logic [3:0]  low_run;
   logic        seen_released;
   logic        confirmed;
   logic [15:0] phase_inc;
   logic [9:0]  blink_inc;
   logic [9:0]  blink_interval;
   logic        blink_hit;
   logic        countdown_done;
   logic        cleanup_done;
   logic        clear;
   fac_mode_type mode_in;

   // Debounce the button; freeze it while resolved
   always_comb begin
      pending       = state_ff.press_pending;
      low_run       = state_ff.low_run;
      seen_released = state_ff.seen_released;
      confirmed     = 1'b0;
      if (state_ff.mode != MODE_RESOLVED) begin
         if (!req.button_level && state_ff.seen_released) begin
            if (state_ff.low_run != LOW_RUN_MAX) begin
               low_run = state_ff.low_run + 4'd1;
            end
            if (low_run >= cfg.debounce_ticks) begin
               pending       = 1'b1;
               seen_released = 1'b0;
               confirmed     = 1'b1;
            end
         end else if (req.button_level) begin
            low_run       = 4'd0;
            seen_released = 1'b1;
         end
      end
   end

   // Advance the saturating counters
   assign phase_inc = (state_ff.phase_ticks == PHASE_MAX) ? PHASE_MAX
                                                          : state_ff.phase_ticks + 16'd1;
   assign blink_inc = (state_ff.blink_ticks == BLINK_MAX) ? BLINK_MAX
                                                          : state_ff.blink_ticks + 10'd1;
   assign blink_interval = (state_ff.mode == MODE_TRANSMIT) ? cfg.fast_blink_ticks
                                                            : cfg.slow_blink_ticks;
   assign blink_hit      = (blink_inc >= blink_interval);
   assign countdown_done = (phase_inc >= cfg.countdown_ticks);
   assign cleanup_done   = (state_ff.phase_ticks >= {6'd0, cfg.cleanup_ticks});

   // Select the next alert state
   always_comb begin
      unique case (state_ff.mode)
         MODE_COUNTDOWN: begin
            if (!req.fall_flag || pending) begin
               mode_in = MODE_READY;
            end else if (countdown_done) begin
               mode_in = MODE_ACTIVE;
            end else begin
               mode_in = MODE_COUNTDOWN;
            end
         end
         MODE_ACTIVE:   mode_in = MODE_TRANSMIT;
         MODE_TRANSMIT: mode_in = pending ? MODE_RESOLVED : MODE_TRANSMIT;
         MODE_RESOLVED: mode_in = cleanup_done ? MODE_READY : MODE_RESOLVED;
         default: begin
            if (req.fall_flag) begin
               mode_in = MODE_COUNTDOWN;
            end else if (pending) begin
               mode_in = MODE_ACTIVE;
            end else begin
               mode_in = MODE_READY;
            end
         end
      endcase
   end

   // Update kind, counters, LEDs and the clear pulse
   always_comb begin
      state_in               = state_ff;
      state_in.mode          = mode_in;
      state_in.press_pending = pending;
      state_in.low_run       = low_run;
      state_in.seen_released = seen_released;
      clear                  = 1'b0;
      unique case (state_ff.mode)
         MODE_COUNTDOWN, MODE_TRANSMIT: begin
            state_in.green_level = 1'b0;
            if (blink_hit) begin
               state_in.blink_ticks = 10'd0;
               state_in.blink_phase = ~state_ff.blink_phase;
               state_in.red_level   = ~state_ff.blink_phase;
            end else begin
               state_in.blink_ticks = blink_inc;
            end
            if (state_ff.mode == MODE_COUNTDOWN) begin
               state_in.phase_ticks = phase_inc;
               if (!req.fall_flag) begin
                  state_in.kind = KIND_NONE;
               end else if (pending) begin
                  state_in.press_pending = 1'b0;
                  state_in.kind          = KIND_NONE;
                  clear                  = 1'b1;
               end
            end else if (pending) begin
               state_in.press_pending = 1'b0;
               state_in.phase_ticks   = 16'd0;
            end
         end
         MODE_ACTIVE: begin
            state_in.blink_ticks = 10'd0;
         end
         MODE_RESOLVED: begin
            state_in.green_level = 1'b0;
            state_in.red_level   = 1'b0;
            state_in.kind        = KIND_NONE;
            clear                = (state_ff.phase_ticks == 16'd0);
            if (!cleanup_done) begin
               state_in.phase_ticks = phase_inc;
            end
         end
         default: begin
            state_in.green_level = 1'b1;
            state_in.red_level   = 1'b0;
            if (pending) begin
               state_in.press_pending = 1'b0;
               state_in.kind          = KIND_MANUAL;
            end
            if (req.fall_flag) begin
               state_in.kind        = KIND_FALL;
               state_in.phase_ticks = 16'd0;
               state_in.blink_ticks = 10'd0;
            end
         end
      endcase
   end

   // Report the values after the tick
   always_comb begin
      rsp.alert_state     = mode_in;
      rsp.alert_kind      = state_in.kind;
      rsp.green_led       = state_in.green_level;
      rsp.red_led         = state_in.red_level;
      rsp.clear_fall      = clear;
      rsp.press_confirmed = confirmed;
   end

endmodule
